// File: sv/fdm_pkg.sv
// fdm_pkg: shared types and codes for the drop-through-match fifo
// no dependencies; used by the interfaces, the cell chain and the controller

package fdm_pkg;

  localparam int unsigned DATA_W = 32;

  // action codes of an input transaction
  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_LIST   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // status codes of a result transaction
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic push;  // write push data into the cell at the tail
    logic rot;   // rotate the occupied cells by one toward the front
  } cell_ctl_t;

endpackage

// File: sv/fdm_if.sv
// fdm_req_if / fdm_rsp_if: valid-ready channels of the drop-through-match fifo
// depends on fdm_pkg

interface fdm_req_if;
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  fdm_pkg::data_t  value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface fdm_rsp_if;
  logic            valid;
  logic            ready;
  fdm_pkg::data_t  item_value;
  logic [1:0]      status;
  logic            last;

  modport source (output valid, item_value, status, last, input ready);
  modport sink   (input valid, item_value, status, last, output ready);
endinterface

// File: sv/fdm_cell.sv
// fdm_cell: one storage cell of the queue chain, holds one entry
// depends on fdm_pkg

module fdm_cell #(
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  fdm_pkg::cell_ctl_t ctl_i,
  input  logic [CW-1:0]      count_i,
  input  fdm_pkg::data_t     push_data_i,
  input  fdm_pkg::data_t     next_data_i,
  input  fdm_pkg::data_t     front_data_i,
  output fdm_pkg::data_t     data_o
);
  import fdm_pkg::*;

  data_t data_q, data_d;
  logic  is_tail_slot;
  logic  is_last_used;

  assign is_tail_slot = (count_i == CW'(IDX));
  assign is_last_used = (count_i == CW'(IDX + 1));

  always_comb begin
    data_d = data_q;
    if (ctl_i.push && is_tail_slot) begin
      data_d = push_data_i;
    end else if (ctl_i.rot) begin
      // last occupied cell takes the front entry, the rest take their neighbor
      data_d = is_last_used ? front_data_i : next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: sv/fdm_ctrl.sv
// fdm_ctrl: sequencer, fill count and result register of the fifo
// depends on fdm_pkg and the fdm_req_if / fdm_rsp_if interfaces

module fdm_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fdm_req_if.sink             req_i,
  fdm_rsp_if.source           rsp_o,
  input  fdm_pkg::data_t      front_data_i,
  output fdm_pkg::cell_ctl_t  ctl_o,
  output logic [CW-1:0]       count_o
);
  import fdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LIST = 3'b010,
    S_SRCH = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] step_q, step_d;
  data_t         key_q, key_d;
  logic          out_valid_q, out_valid_d;
  data_t         item_q, item_d;
  logic [1:0]    status_q, status_d;
  logic          last_q, last_d;
  logic          slot_free;
  logic          accept;
  logic          at_end;

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept      = req_i.valid && req_i.ready;
  assign at_end      = (step_q == CW'(count_q - 1'b1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    item_d      = item_q;
    status_d    = status_q;
    last_d      = last_q;
    ctl_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.action)
            ACT_PUSH: begin
              out_valid_d = 1'b1;
              item_d      = '0;
              last_d      = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                status_d   = ST_OK;
                ctl_o.push = 1'b1;
                count_d    = count_q + 1'b1;
              end
            end
            ACT_LIST: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                item_d      = '0;
                status_d    = ST_EMPTY;
                last_d      = 1'b1;
              end else begin
                step_d  = '0;
                state_d = S_LIST;
              end
            end
            ACT_REMOVE: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                item_d      = '0;
                status_d    = ST_NOT_FOUND;
                last_d      = 1'b1;
              end else begin
                key_d   = req_i.value;
                step_d  = '0;
                state_d = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          item_d      = front_data_i;
          status_d    = ST_OK;
          last_d      = at_end;
          ctl_o.rot   = 1'b1;
          step_d      = step_q + 1'b1;
          if (at_end) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SRCH: begin
        if (slot_free) begin
          ctl_o.rot = 1'b1;
          if (front_data_i == key_q) begin
            // popped entries sit past the new count, so they fall away
            count_d     = CW'(count_q - step_q - 1'b1);
            out_valid_d = 1'b1;
            item_d      = '0;
            status_d    = ST_OK;
            last_d      = 1'b1;
            state_d     = S_IDLE;
          end else if (at_end) begin
            // full turn of the ring, order is back as it was
            out_valid_d = 1'b1;
            item_d      = '0;
            status_d    = ST_NOT_FOUND;
            last_d      = 1'b1;
            state_d     = S_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    item_q   <= item_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.item_value = item_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.last       = last_q;
  assign count_o          = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> count_q != '0)
    else $error("walk started on an empty queue");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> step_q < count_q)
    else $error("walk step past the occupied cells");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.action == ACT_PUSH && count_q != CW'(DEPTH)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the queue");

  a_list_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |=> count_q == $past(count_q))
    else $error("list changed the fill count");

endmodule

// File: sv/fifo_with_drop_through_match.sv
// fifo_with_drop_through_match: bounded fifo of signed 32-bit values
// depends on fdm_pkg, fdm_if, fdm_cell and fdm_ctrl
//
//   channel | dir | fields                         | transaction per
//   req_i   | in  | action, value                  | command
//   rsp_o   | out | item_value, status, last       | result line
//
// push is answered straight from idle with a single result line; list gives one
// result line per held entry; remove examines entries from the front up to the
// first match (at most the fill count); the walk is done by the cell chain,
// which rotates one entry past the front comparator per cycle while the result
// register is free
// reset clears the fill count and the sequencer; cell contents are undefined
// until pushed and are never read before that
// a stalled result holds the walk in place; a new command is taken only when
// the sequencer is idle and the result register is free or being drained

module fifo_with_drop_through_match #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdm_req_if.sink    req_i,
  fdm_rsp_if.source  rsp_o
);
  import fdm_pkg::*;

  // fill count needs to reach depth itself
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cell_ctl_t     cell_ctl;
  logic [CW-1:0] count;
  data_t         cell_data [DEPTH];

  // sequencer: decodes commands, walks the chain, owns the result register
  fdm_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .front_data_i (cell_data[0]),
    .ctl_o        (cell_ctl),
    .count_o      (count)
  );

  // chain of cells, cell 0 is the front of the queue
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    data_t next_data;

    // the tail cell only ever wraps, so it sees the front as its neighbor
    if (g == DEPTH - 1) begin : g_tail
      assign next_data = cell_data[0];
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end

    fdm_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl),
      .count_i      (count),
      .push_data_i  (req_i.value),
      .next_data_i  (next_data),
      .front_data_i (cell_data[0]),
      .data_o       (cell_data[g])
    );
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for fifo_with_drop_through_match, a directed pass then random traffic
// needs fdm_pkg, fdm_req_if / fdm_rsp_if and the block itself

module tb;
  import fdm_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned SLOT_W       = $clog2(DEPTH);
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;     // undefined action, block drops it
  localparam int unsigned RANDOM_CMDS  = 250;
  localparam int unsigned STALL_AFTER  = 120;      // commands taken before the long hold-off
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 4 * DEPTH;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_W:0]   fill_t;

  typedef struct packed {
    logic [1:0] action;
    data_t      value;
  } fifo_cmd_t;

  typedef struct packed {
    data_t      item_value;
    logic [1:0] status;
    logic       last;
  } fifo_line_t;

  // clock, reset and every block input start at known values
  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       req_valid  = 1'b0;
  logic [1:0] req_action = ACT_PUSH;
  data_t      req_value  = '0;
  logic       rsp_ready  = 1'b0;

  fdm_req_if req_if ();
  fdm_rsp_if rsp_if ();

  assign req_if.valid  = req_valid;
  assign req_if.action = req_action;
  assign req_if.value  = req_value;
  assign rsp_if.ready  = rsp_ready;

  fifo_with_drop_through_match #(
    .DEPTH (DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the ring, updated on each accepted command
  data_t       fifo_mem [DEPTH];
  slot_t       fifo_head = '0;
  fill_t       fifo_count = '0;

  fifo_cmd_t   pending_cmds [$];   // commands not yet offered to the block
  fifo_line_t  lines_due [$];      // result lines still owed by the block

  int unsigned cmds_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_wait = 0;
  int unsigned send_burst = 0;
  int unsigned rdy_wait = 0;
  int unsigned rdy_burst = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  // gap length for either side: mostly none or short, now and then long,
  // with occasional bursts where no gap is taken at all
  function automatic int unsigned next_gap(inout int unsigned burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if (roll < 4) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // small signed pool so that removes often hit and duplicates appear,
  // otherwise a full-width word so every bit toggles
  function automatic data_t rand_value();
    if ($urandom_range(0, 99) < 75) return data_t'(int'($urandom_range(0, 7)) - 4);
    return data_t'($urandom());
  endfunction

  task automatic queue_cmd(input logic [1:0] action, input data_t value);
    fifo_cmd_t cmd;
    cmd.action = action;
    cmd.value  = value;
    pending_cmds.push_back(cmd);
  endtask

  // result lines caused by one command, applied to the shadow ring
  task automatic predict_lines(input fifo_cmd_t cmd);
    fifo_line_t  line;
    bit          hit;
    int unsigned i;
    hit             = 1'b0;
    line.item_value = '0;
    line.status     = ST_OK;
    line.last       = 1'b1;
    case (cmd.action)
      ACT_PUSH: begin
        // full queue drops the value and leaves the ring alone
        if (fifo_count == DEPTH) begin
          line.status = ST_FULL;
        end else begin
          fifo_mem[slot_t'((fifo_head + fifo_count) % DEPTH)] = cmd.value;
          fifo_count = fifo_count + 1'b1;
        end
        lines_due.push_back(line);
      end
      ACT_LIST: begin
        if (fifo_count == 0) begin
          line.status = ST_EMPTY;
          lines_due.push_back(line);
        end else begin
          for (i = 0; i < fifo_count; i++) begin
            line.item_value = fifo_mem[slot_t'((fifo_head + i) % DEPTH)];
            line.last       = (i + 1 == fifo_count);
            lines_due.push_back(line);
          end
        end
      end
      ACT_REMOVE: begin
        // drop everything from the front through the first match
        line.status = ST_NOT_FOUND;
        for (i = 0; i < fifo_count && !hit; i++) begin
          if (fifo_mem[slot_t'((fifo_head + i) % DEPTH)] == cmd.value) begin
            hit         = 1'b1;
            fifo_count  = fill_t'(fifo_count - (i + 1));
            // an emptied queue restarts at slot zero
            fifo_head   = (fifo_count == 0) ? slot_t'(0) : slot_t'((fifo_head + i + 1) % DEPTH);
            line.status = ST_OK;
          end
        end
        lines_due.push_back(line);
      end
      default: begin
        // unused action: no lines, no state change
      end
    endcase
  endtask

  // driver: offers pending commands, predicts on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    fifo_cmd_t   cmd;
    int unsigned gap;
    if (!rst_ni) begin
      req_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (req_valid && req_if.ready) begin
        cmd.action = req_action;
        cmd.value  = req_value;
        predict_lines(cmd);
        cmds_taken <= cmds_taken + 1;
      end
      // valid only moves when nothing is on offer or the offer was just taken
      if (!req_valid || req_if.ready) begin
        if (send_wait != 0) begin
          req_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_cmds.size() != 0) begin
          cmd = pending_cmds.pop_front();
          req_valid  <= 1'b1;
          req_action <= cmd.action;
          req_value  <= cmd.value;
          gap = next_gap(send_burst);
          send_wait <= gap;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result ready: random gaps, plus one long hold-off mid run so the
  // block backs up and stalls its command side
  always @(posedge clk_i or negedge rst_ni) begin : drive_rsp_ready
    int unsigned gap;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else if (!stall_done && cmds_taken >= STALL_AFTER) begin
      stall_done <= 1'b1;
      stall_left <= STALL_CYCLES;
      rsp_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (rdy_wait != 0) begin
      rdy_wait  <= rdy_wait - 1;
      rsp_ready <= 1'b0;
    end else if (rsp_ready && rsp_if.valid) begin
      // a line just went through: maybe pause before the next
      gap = next_gap(rdy_burst);
      rsp_ready <= (gap == 0);
      rdy_wait  <= (gap == 0) ? 0 : gap - 1;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // monitor: each accepted line against the oldest one owed
  always @(posedge clk_i) begin : check_rsp
    fifo_line_t got;
    fifo_line_t want;
    if (rst_ni && rsp_if.valid && rsp_ready) begin
      got.item_value = rsp_if.item_value;
      got.status     = rsp_if.status;
      got.last       = rsp_if.last;
      if (lines_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t tb: unexpected line, expected none, actual value %0d status %0d last %0b",
                   $time, got.item_value, got.status, got.last);
      end else begin
        want = lines_due.pop_front();
        if (got.item_value !== want.item_value || got.status !== want.status ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t tb: line mismatch, expected value %0d status %0d last %0b, %s",
                     $time, want.item_value, want.status, want.last,
                     $sformatf("actual value %0d status %0d last %0b",
                               got.item_value, got.status, got.last));
        end
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : run
    int unsigned real_cmds;
    int unsigned push_pct;
    int unsigned roll;

    // directed: empty-queue cases and the unused action first
    queue_cmd(ACT_LIST, '0);
    queue_cmd(ACT_REMOVE, '0);
    queue_cmd(ACT_UNUSED, 32'sh7fffffff);
    // value extremes and bit patterns
    queue_cmd(ACT_PUSH, 32'sh80000000);
    queue_cmd(ACT_PUSH, 32'sh7fffffff);
    queue_cmd(ACT_PUSH, 32'sh00000000);
    queue_cmd(ACT_PUSH, -32'sd1);
    queue_cmd(ACT_PUSH, 32'sh55555555);
    queue_cmd(ACT_PUSH, 32'shaaaaaaaa);
    for (int unsigned k = 1; k <= 4; k++) queue_cmd(ACT_PUSH, data_t'(k));
    // match in second place: two entries leave, head moves off zero
    queue_cmd(ACT_REMOVE, 32'sh7fffffff);
    // fill up past full so the ring wraps and the last push is dropped
    for (int unsigned k = 10; k <= 18; k++) queue_cmd(ACT_PUSH, data_t'(k));
    queue_cmd(ACT_LIST, '0);
    queue_cmd(ACT_REMOVE, 32'sh12345678);
    // match on the tail entry empties the queue
    queue_cmd(ACT_REMOVE, data_t'(17));
    queue_cmd(ACT_LIST, '0);

    // random: phases of differing push weight so the queue swings
    // between empty and full
    real_cmds = 0;
    push_pct  = 55;
    while (real_cmds < RANDOM_CMDS) begin
      if (real_cmds % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 30;
          1:       push_pct = 55;
          default: push_pct = 80;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        queue_cmd(ACT_UNUSED, rand_value());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
          queue_cmd(ACT_PUSH, rand_value());
        else if (roll < push_pct + (100 - push_pct) / 3)
          queue_cmd(ACT_LIST, rand_value());
        else
          queue_cmd(ACT_REMOVE, rand_value());
        real_cmds++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every command to go in and every owed line to come out
    while (pending_cmds.size() != 0 || req_valid || lines_due.size() != 0)
      @(negedge clk_i);
    // room for any stray line still in flight
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && lines_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/fdm_pkg.sv
sv/fdm_if.sv
sv/fdm_cell.sv
sv/fdm_ctrl.sv
sv/fifo_with_drop_through_match.sv
bench/tb.sv
